// File: sv/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared types, codes and saturating Q23.40 helpers for the UHF Fock builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufe_pkg;

  localparam int unsigned MaxBasis = 8;
  localparam int unsigned PairW    = 6;
  localparam int unsigned DataW    = 64;

  localparam logic [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};

  typedef enum logic [2:0] {
    FN_LOAD_H0  = 3'd0,
    FN_LOAD_C   = 3'd1,
    FN_LOAD_X   = 3'd2,
    FN_LOAD_PA  = 3'd3,
    FN_LOAD_PB  = 3'd4,
    FN_COMPUTE  = 3'd5
  } func_e;

  typedef enum logic {
    CFG_BASIS = 1'b0,
    CFG_CORE  = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    PR_J  = 3'd0,
    PR_KA = 3'd1,
    PR_KB = 3'd2,
    PR_SH = 3'd3,
    PR_SJ = 3'd4,
    PR_SA = 3'd5,
    PR_SB = 3'd6
  } prod_e;

  typedef enum logic [2:0] {
    EN_NONE  = 3'd0,
    EN_HALFJ = 3'd1,
    EN_SUBA  = 3'd2,
    EN_SUBB  = 3'd3,
    EN_CORE  = 3'd4
  } estep_e;

  typedef struct packed {
    logic             rd_en;
    logic             rd_tail;
    logic [PairW-1:0] p;
    logic [PairW-1:0] q;
    logic             ptot_ld;
    logic             mul_start;
    prod_e            mul_sel;
    logic             clr_pq;
    logic             clr_all;
    logic             fock_ld;
    estep_e           e_step;
  } cmd_t;

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    logic [DataW-1:0] s;
    s = a + b;
    if ((a[DataW-1] == b[DataW-1]) && (s[DataW-1] != a[DataW-1]))
      return a[DataW-1] ? SatMin : SatMax;
    return s;
  endfunction

  function automatic logic [DataW-1:0] sat_sub(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    logic [DataW-1:0] d;
    d = a - b;
    if ((a[DataW-1] != b[DataW-1]) && (d[DataW-1] != a[DataW-1]))
      return a[DataW-1] ? SatMin : SatMax;
    return d;
  endfunction

  function automatic logic [DataW-1:0] half_of(input logic [DataW-1:0] x);
    return {x[DataW-1], x[DataW-1:1]};
  endfunction

endpackage

`default_nettype wire

// File: sv/uhf_fock_and_energy_build.sv
// A compute request over P = n*n pairs, for each element, reads the stores
// and runs three products (J, K alpha, K beta) per inner pair, then four
// energy-sum products; the energy steps follow the last element, and each
// element waits for out_ready_i.
// Throughput: one request at a time; intake stalls until the last element.
// Reset: asynchronous active low; basis size 8, core repulsion 0, stores
// hold undefined data until loaded.
// ----------------------------------------------------------------------------
// uhf_fock_and_energy_build
// UHF Fock matrix and total energy builder, Q23.40 saturating fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uhf_fock_and_energy_build (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         column_index_i,
  input  logic signed [63:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         element_index_o,
  output logic signed [63:0] fock_alpha_o,
  output logic signed [63:0] fock_beta_o,
  output logic signed [63:0] total_energy_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_wdata_i
);
  import ufe_pkg::*;

  cmd_t cmd;
  logic mul_done;
  logic load;

  assign load = in_valid_i & in_ready_o;

  ufe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .mul_done_i  (mul_done)
  );

  ufe_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mul_done_o      (mul_done),
    .load_i          (load),
    .func_i          (func_i),
    .row_index_i     (row_index_i),
    .column_index_i  (column_index_i),
    .value_i         (value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .element_index_o (element_index_o),
    .fock_alpha_o    (fock_alpha_o),
    .fock_beta_o     (fock_beta_o),
    .total_energy_o  (total_energy_o)
  );

endmodule

`default_nettype wire

// File: sv/ufe_mul.sv
// ----------------------------------------------------------------------------
// ufe_mul
// Iterative Q23.40 multiplier: four 32x32 partial products, round, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufe_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ufe_pkg::DataW-1:0] a_i,
  input  logic [ufe_pkg::DataW-1:0] b_i,
  output logic                      done_o,
  output logic [ufe_pkg::DataW-1:0] res_o
);
  import ufe_pkg::*;

  localparam logic [127:0] RoundHalf = 128'h80_0000_0000;

  logic             busy_q;
  logic [2:0]       step_q;
  logic             done_q;
  logic [63:0]      ma_q, mb_q;
  logic             neg_q;
  logic [127:0]     acc_q;
  logic [63:0]      res_q;
  logic [31:0]      op_a, op_b;
  logic [63:0]      pp;
  logic [127:0]     pp_sh;
  logic [127:0]     rnd;
  logic [24:0]      top;

  always_comb begin
    op_a = step_q[0] ? ma_q[63:32] : ma_q[31:0];
    op_b = step_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp   = op_a * op_b;
    case (step_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    rnd = acc_q + RoundHalf;
    top = rnd[127:103];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[63] ? (~a_i + 64'd1) : a_i;
      mb_q  <= b_i[63] ? (~b_i + 64'd1) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd4) begin
        acc_q <= acc_q + pp_sh;
      end else if (step_q == 3'd4) begin
        if (neg_q) acc_q <= ~acc_q + 128'd1;
      end else begin
        if ((top != '0) && (top != '1)) res_q <= rnd[127] ? SatMin : SatMax;
        else res_q <= rnd[103:40];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// File: sv/ufe_datapath.sv
// ----------------------------------------------------------------------------
// ufe_datapath
// Stores, multiply-accumulate registers, Fock element and energy datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufe_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ufe_pkg::cmd_t             cmd_i,
  output logic                      mul_done_o,
  input  logic                      load_i,
  input  logic [2:0]                func_i,
  input  logic [5:0]                row_index_i,
  input  logic [5:0]                column_index_i,
  input  logic [63:0]               value_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [63:0]               cfg_wdata_i,
  output logic [5:0]                element_index_o,
  output logic [63:0]               fock_alpha_o,
  output logic [63:0]               fock_beta_o,
  output logic [63:0]               total_energy_o
);
  import ufe_pkg::*;

  logic [63:0] h0_mem [64];
  logic [63:0] pa_mem [64];
  logic [63:0] pb_mem [64];
  logic [63:0] c_mem  [4096];
  logic [63:0] x_mem  [4096];

  logic [63:0] h0_rd_q, pa_rd_q, pb_rd_q, c_rd_q, x_rd_q;
  logic [5:0]  vec_addr;
  logic [11:0] mat_addr;

  logic [63:0] core_q;
  logic [63:0] ptot_q;
  logic [63:0] j_q, ka_q, kb_q;
  logic [63:0] sh_q, sj_q, sa_q, sb_q;
  logic [63:0] e_q;
  prod_e       sel_q;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_done;
  logic [63:0] base;
  logic [5:0]  idx_q;
  logic [63:0] fa_q, fb_q, en_q;

  assign vec_addr = cmd_i.rd_tail ? cmd_i.p : cmd_i.q;
  assign mat_addr = {cmd_i.p, cmd_i.q};

  always_ff @(posedge clk_i) begin
    if (load_i && func_i == FN_LOAD_H0) h0_mem[row_index_i] <= value_i;
    if (cmd_i.rd_en) h0_rd_q <= h0_mem[vec_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_i && func_i == FN_LOAD_PA) pa_mem[row_index_i] <= value_i;
    if (cmd_i.rd_en) pa_rd_q <= pa_mem[vec_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_i && func_i == FN_LOAD_PB) pb_mem[row_index_i] <= value_i;
    if (cmd_i.rd_en) pb_rd_q <= pb_mem[vec_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_i && func_i == FN_LOAD_C) c_mem[{row_index_i, column_index_i}] <= value_i;
    if (cmd_i.rd_en) c_rd_q <= c_mem[mat_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_i && func_i == FN_LOAD_X) x_mem[{row_index_i, column_index_i}] <= value_i;
    if (cmd_i.rd_en) x_rd_q <= x_mem[mat_addr];
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      PR_J:    begin mul_a = c_rd_q;  mul_b = ptot_q;  end
      PR_KA:   begin mul_a = x_rd_q;  mul_b = pa_rd_q; end
      PR_KB:   begin mul_a = x_rd_q;  mul_b = pb_rd_q; end
      PR_SH:   begin mul_a = ptot_q;  mul_b = h0_rd_q; end
      PR_SJ:   begin mul_a = ptot_q;  mul_b = j_q;     end
      PR_SA:   begin mul_a = pa_rd_q; mul_b = ka_q;    end
      PR_SB:   begin mul_a = pb_rd_q; mul_b = kb_q;    end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  ufe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign mul_done_o = mul_done;
  assign base = sat_add(h0_rd_q, j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_q <= '0;
      e_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == {1'b0, CFG_CORE}) core_q <= cfg_wdata_i;
      case (cmd_i.e_step)
        EN_HALFJ: e_q <= sat_add(sh_q, half_of(sj_q));
        EN_SUBA:  e_q <= sat_sub(e_q, half_of(sa_q));
        EN_SUBB:  e_q <= sat_sub(e_q, half_of(sb_q));
        EN_CORE:  e_q <= sat_add(e_q, core_q);
        default:  e_q <= e_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) sel_q <= cmd_i.mul_sel;
    if (cmd_i.ptot_ld) ptot_q <= sat_add(pa_rd_q, pb_rd_q);
    if (cmd_i.clr_pq) begin
      j_q  <= '0;
      ka_q <= '0;
      kb_q <= '0;
    end
    if (cmd_i.clr_all) begin
      sh_q <= '0;
      sj_q <= '0;
      sa_q <= '0;
      sb_q <= '0;
    end
    if (mul_done) begin
      case (sel_q)
        PR_J:    j_q  <= sat_add(j_q, mul_res);
        PR_KA:   ka_q <= sat_add(ka_q, mul_res);
        PR_KB:   kb_q <= sat_add(kb_q, mul_res);
        PR_SH:   sh_q <= sat_add(sh_q, mul_res);
        PR_SJ:   sj_q <= sat_add(sj_q, mul_res);
        PR_SA:   sa_q <= sat_add(sa_q, mul_res);
        PR_SB:   sb_q <= sat_add(sb_q, mul_res);
        default: ;
      endcase
    end
    if (cmd_i.fock_ld) begin
      idx_q <= cmd_i.p;
      fa_q  <= sat_sub(base, ka_q);
      fb_q  <= sat_sub(base, kb_q);
      en_q  <= '0;
    end else if (cmd_i.e_step == EN_CORE) begin
      en_q  <= sat_add(e_q, core_q);
    end
  end

  assign element_index_o = idx_q;
  assign fock_alpha_o    = fa_q;
  assign fock_beta_o     = fb_q;
  assign total_energy_o  = en_q;

endmodule

`default_nettype wire

// File: sv/ufe_ctrl.sv
// ----------------------------------------------------------------------------
// ufe_ctrl
// Sequencer: intake, pair loops, multiply scheduling, energy steps, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    func_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          last_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_wdata_i,
  output ufe_pkg::cmd_t cmd_o,
  input  logic          mul_done_i
);
  import ufe_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PINIT = 4'd1;
  localparam logic [3:0] S_QRD   = 4'd2;
  localparam logic [3:0] S_QWT   = 4'd3;
  localparam logic [3:0] S_PRD   = 4'd4;
  localparam logic [3:0] S_PWT   = 4'd5;
  localparam logic [3:0] S_MGO   = 4'd6;
  localparam logic [3:0] S_MWT   = 4'd7;
  localparam logic [3:0] S_FOCK  = 4'd8;
  localparam logic [3:0] S_E1    = 4'd9;
  localparam logic [3:0] S_E2    = 4'd10;
  localparam logic [3:0] S_E3    = 4'd11;
  localparam logic [3:0] S_E4    = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0] state_q, state_d;
  logic [5:0] p_q, p_d, q_q, q_d;
  prod_e      sel_q, sel_d;
  logic [3:0] basis_q;
  logic [3:0] n_eff;
  logic [7:0] pairs;
  logic [5:0] pm1;

  always_comb begin
    if (basis_q == 4'd0) n_eff = 4'd1;
    else if (basis_q > 4'(MaxBasis)) n_eff = 4'(MaxBasis);
    else n_eff = basis_q;
    pairs = {4'd0, n_eff} * {4'd0, n_eff};
    pm1   = 6'(pairs - 8'd1);
  end

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    q_d     = q_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.p = p_q;
    cmd_o.q = q_q;
    cmd_o.mul_sel = sel_q;
    cmd_o.e_step  = EN_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    last_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && func_i == FN_COMPUTE) begin
          cmd_o.clr_all = 1'b1;
          p_d     = '0;
          state_d = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd_o.clr_pq = 1'b1;
        q_d     = '0;
        state_d = S_QRD;
      end
      S_QRD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_QWT;
      end
      S_QWT: begin
        cmd_o.ptot_ld = 1'b1;
        sel_d   = PR_J;
        state_d = S_MGO;
      end
      S_PRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_tail = 1'b1;
        state_d = S_PWT;
      end
      S_PWT: begin
        cmd_o.ptot_ld = 1'b1;
        sel_d   = PR_SH;
        state_d = S_MGO;
      end
      S_MGO: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_MWT;
      end
      S_MWT: begin
        if (mul_done_i) begin
          if (sel_q == PR_KB) begin
            if (q_q == pm1) begin
              state_d = S_PRD;
            end else begin
              q_d     = q_q + 6'd1;
              state_d = S_QRD;
            end
          end else if (sel_q == PR_SB) begin
            state_d = S_FOCK;
          end else begin
            sel_d   = prod_e'(sel_q + 3'd1);
            state_d = S_MGO;
          end
        end
      end
      S_FOCK: begin
        cmd_o.fock_ld = 1'b1;
        state_d = (p_q == pm1) ? S_E1 : S_EMIT;
      end
      S_E1: begin
        cmd_o.e_step = EN_HALFJ;
        state_d = S_E2;
      end
      S_E2: begin
        cmd_o.e_step = EN_SUBA;
        state_d = S_E3;
      end
      S_E3: begin
        cmd_o.e_step = EN_SUBB;
        state_d = S_E4;
      end
      S_E4: begin
        cmd_o.e_step = EN_CORE;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        last_o      = (p_q == pm1);
        if (out_ready_i) begin
          if (p_q == pm1) begin
            state_d = S_IDLE;
          end else begin
            p_d     = p_q + 6'd1;
            state_d = S_PINIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q     <= '0;
      q_q     <= '0;
      sel_q   <= PR_J;
      basis_q <= 4'd8;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      q_q     <= q_d;
      sel_q   <= sel_d;
      if (cfg_we_i && cfg_index_i == {1'b0, CFG_BASIS}) basis_q <= cfg_wdata_i[3:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/ufe_checker.sv
// ----------------------------------------------------------------------------
// ufe_checker
// Port-level properties of the UHF Fock builder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  func_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  element_index_o,
  input logic [63:0] fock_alpha_o,
  input logic [63:0] total_energy_o,
  input logic        last_o
);
  import ufe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_index_o)
      && $stable(fock_alpha_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_no_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken while results pending");

  a_energy_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> total_energy_o == '0)
    else $error("energy nonzero before last element");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FN_COMPUTE |=> !in_ready_o)
    else $error("compute did not stall intake");

endmodule

bind uhf_fock_and_energy_build ufe_checker u_ufe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .func_i          (func_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .element_index_o (element_index_o),
  .fock_alpha_o    (fock_alpha_o),
  .total_energy_o  (total_energy_o),
  .last_o          (last_o)
);

`default_nettype wire

// File: sim/fock_scoreboard.sv
// ----------------------------------------------------------------------------
// fock_scoreboard
// Watches the load/compute request channel, the register port and the Fock
// element channel. Keeps its own copy of the stores and registers, works out
// every Fock element and the total energy for each compute request, and
// compares them field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fock_scoreboard
  import ufe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         func_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         column_index_i,
  input  logic [63:0]        value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [5:0]         element_index_i,
  input  logic [63:0]        fock_alpha_i,
  input  logic [63:0]        fock_beta_i,
  input  logic [63:0]        total_energy_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 elements_seen_o
);

  typedef struct {
    logic [5:0]  idx;
    logic [63:0] fa;
    logic [63:0] fb;
    logic [63:0] energy;
    logic        lst;
  } fock_elem_t;

  fock_elem_t  fock_expected_q[$];
  logic [63:0] h0_mem[64];
  logic [63:0] pa_mem[64];
  logic [63:0] pb_mem[64];
  logic [63:0] coul_mem[4096];
  logic [63:0] exch_mem[4096];
  logic [3:0]  basis_reg;
  logic [63:0] core_reg;

  function automatic logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SatMin : SatMax;
    return s[63:0];
  endfunction

  function automatic logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? SatMin : SatMax;
    return d[63:0];
  endfunction

  // exact product, round half up, >> 40, saturate
  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic signed [127:0] full;
    full = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    full = full + {88'd0, 1'b1, 39'd0};
    full = full >>> 40;
    if (!((&full[127:63]) || !(|full[127:63]))) return full[127] ? SatMin : SatMax;
    return full[63:0];
  endfunction

  function automatic logic [63:0] q_half(logic [63:0] x);
    return {x[63], x[63:1]};
  endfunction

  task automatic predict_fock_run();
    int unsigned n, pairs;
    logic [63:0] ptot[64];
    logic [63:0] jv, ka, kb, base, sh, sj, sa, sb, e;
    fock_elem_t  el;
    n = (basis_reg == 0) ? 1 : (basis_reg > MaxBasis) ? MaxBasis : basis_reg;
    pairs = n * n;
    sh = '0; sj = '0; sa = '0; sb = '0;
    for (int q = 0; q < pairs; q++) ptot[q] = q_add(pa_mem[q], pb_mem[q]);
    for (int p = 0; p < pairs; p++) begin
      jv = '0; ka = '0; kb = '0;
      for (int q = 0; q < pairs; q++) begin
        jv = q_add(jv, q_mul(coul_mem[p*64+q], ptot[q]));
        ka = q_add(ka, q_mul(exch_mem[p*64+q], pa_mem[q]));
        kb = q_add(kb, q_mul(exch_mem[p*64+q], pb_mem[q]));
      end
      base = q_add(h0_mem[p], jv);
      el.idx = p[5:0];
      el.fa = q_sub(base, ka);
      el.fb = q_sub(base, kb);
      el.energy = '0;
      el.lst = 1'b0;
      fock_expected_q.push_back(el);
      sh = q_add(sh, q_mul(ptot[p], h0_mem[p]));
      sj = q_add(sj, q_mul(ptot[p], jv));
      sa = q_add(sa, q_mul(pa_mem[p], ka));
      sb = q_add(sb, q_mul(pb_mem[p], kb));
    end
    e = q_add(sh, q_half(sj));
    e = q_sub(e, q_half(sa));
    e = q_sub(e, q_half(sb));
    e = q_add(e, core_reg);
    fock_expected_q[$].energy = e;
    fock_expected_q[$].lst = 1'b1;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fock_elem_t el;
    if (!rst_ni) begin
      fock_expected_q.delete();
      basis_reg = 4'd8;
      core_reg = '0;
      fail_count_o = 0;
      elements_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == {1'b0, CFG_BASIS}) basis_reg = cfg_wdata_i[3:0];
        else if (cfg_index_i == {1'b0, CFG_CORE}) core_reg = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        case (func_i)
          FN_LOAD_H0: h0_mem[row_index_i] = value_i;
          FN_LOAD_C:  coul_mem[{row_index_i, column_index_i}] = value_i;
          FN_LOAD_X:  exch_mem[{row_index_i, column_index_i}] = value_i;
          FN_LOAD_PA: pa_mem[row_index_i] = value_i;
          FN_LOAD_PB: pb_mem[row_index_i] = value_i;
          FN_COMPUTE: predict_fock_run();
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        elements_seen_o++;
        if (fock_expected_q.size() == 0) begin
          $display("%0t: unexpected element index %0d", $time, element_index_i);
          fail_count_o++;
        end else begin
          el = fock_expected_q.pop_front();
          check_field("element_index", 64'(el.idx), 64'(element_index_i));
          check_field("fock_alpha", el.fa, fock_alpha_i);
          check_field("fock_beta", el.fb, fock_beta_i);
          check_field("total_energy", el.energy, total_energy_i);
          check_field("last", 64'(el.lst), 64'(last_i));
        end
      end
    end
    pending_o = fock_expected_q.size();
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives loads, spare function codes, compute requests and register writes
// into the UHF Fock builder with random idling on both channels; the
// scoreboard beside the block predicts and checks every Fock element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ufe_pkg::*;

  localparam logic [2:0] FnSpare6  = 3'd6;
  localparam logic [2:0] FnSpare7  = 3'd7;
  localparam logic [1:0] CfgSpare2 = 2'd2;
  localparam logic [1:0] CfgSpare3 = 2'd3;
  localparam logic [1:0] CfgBasisIdx = {1'b0, CFG_BASIS};
  localparam logic [1:0] CfgCoreIdx  = {1'b0, CFG_CORE};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0, last;
  logic [2:0] func = '0;
  logic [5:0] row = '0, col = '0, elem_idx;
  logic signed [63:0] value = '0, fa, fb, energy;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  int fail_count, pending, elements_seen;

  int idle_pct = 11;
  int requests_sent = 0, computes_sent = 0;
  int unsigned cur_pairs = 64;
  bit h0_set[64], pa_set[64], pb_set[64], c_set[4096], x_set[4096];

  always #2 clk_i = ~clk_i;

  uhf_fock_and_energy_build DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .row_index_i(row), .column_index_i(col), .value_i(value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .element_index_o(elem_idx), .fock_alpha_o(fa), .fock_beta_o(fb),
    .total_energy_o(energy), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  fock_scoreboard u_scoreboard (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .func_i(func),
    .row_index_i(row), .column_index_i(col), .value_i(value),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .element_index_i(elem_idx), .fock_alpha_i(fa), .fock_beta_i(fb),
    .total_energy_i(energy), .last_i(last),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .elements_seen_o(elements_seen)
  );

  always @(negedge clk_i) out_ready <= ($urandom_range(0, 99) >= idle_pct);

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {{22{r[41]}}, r[41:0]};
      5, 6:          return {{10{r[53]}}, r[53:0]};
      7, 8:          return r;
      default: begin
        case ($urandom_range(0, 4))
          0: return SatMin;
          1: return SatMax;
          2: return '0;
          3: return 64'd1;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_request(logic [2:0] f, logic [5:0] r, logic [5:0] c, logic [63:0] v);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk_i);
    in_valid = 1'b1; func = f; row = r; col = c; value = v;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid = 1'b0;
    case (f)
      FN_LOAD_H0: h0_set[r] = 1'b1;
      FN_LOAD_C:  c_set[{r, c}] = 1'b1;
      FN_LOAD_X:  x_set[{r, c}] = 1'b1;
      FN_LOAD_PA: pa_set[r] = 1'b1;
      FN_LOAD_PB: pb_set[r] = 1'b1;
      default: ;
    endcase
    if (f != FnSpare6 && f != FnSpare7) requests_sent++;
    if (f == FN_COMPUTE) computes_sent++;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    wait_drained();
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CfgBasisIdx)
      cur_pairs = (data[3:0] == 0) ? 1 : (data[3:0] > MaxBasis) ? 64 : data[3:0] * data[3:0];
  endtask

  // loads every entry the next compute reads that was never written, then sends the compute
  task automatic compute_filled();
    for (int p = 0; p < cur_pairs; p++) begin
      if (!h0_set[p]) send_request(FN_LOAD_H0, 6'(p), 6'd0, pick_value());
      if (!pa_set[p]) send_request(FN_LOAD_PA, 6'(p), 6'd0, pick_value());
      if (!pb_set[p]) send_request(FN_LOAD_PB, 6'(p), 6'd0, pick_value());
      for (int q = 0; q < cur_pairs; q++) begin
        if (!c_set[p*64+q]) send_request(FN_LOAD_C, 6'(p), 6'(q), pick_value());
        if (!x_set[p*64+q]) send_request(FN_LOAD_X, 6'(p), 6'(q), pick_value());
      end
    end
    send_request(FN_COMPUTE, 6'($urandom), 6'($urandom), {$urandom, $urandom});
  endtask

  initial begin
    int phase, burst, pick;
    logic [2:0] f;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, spare codes and registers, basis size zero, one and two
    write_reg(CfgBasisIdx, 64'd0);
    write_reg(CfgCoreIdx, SatMax);
    send_request(FN_LOAD_H0, 6'd0, 6'd63, SatMax);
    send_request(FN_LOAD_C, 6'd0, 6'd0, SatMin);
    send_request(FN_LOAD_X, 6'd0, 6'd0, SatMax);
    send_request(FN_LOAD_PA, 6'd0, 6'd0, SatMin);
    send_request(FN_LOAD_PB, 6'd0, 6'd0, SatMin);
    send_request(FnSpare6, 6'd63, 6'd63, '1);
    send_request(FnSpare7, 6'd0, 6'd0, '0);
    compute_filled();
    write_reg(CfgBasisIdx, 64'd1);
    write_reg(CfgCoreIdx, SatMin);
    send_request(FN_LOAD_PA, 6'd0, 6'd0, 64'h0000_0100_0000_0000);
    send_request(FN_LOAD_PB, 6'd0, 6'd0, 64'hFFFF_FF00_0000_0000);
    compute_filled();
    write_reg(CfgSpare2, '1);
    write_reg(CfgSpare3, '1);
    write_reg(CfgBasisIdx, 64'd2);
    write_reg(CfgCoreIdx, 64'h0000_0200_0000_0000);
    send_request(FN_LOAD_C, 6'd63, 6'd63, 64'h1234_5678_9ABC_DEF0);
    send_request(FN_LOAD_X, 6'd63, 6'd0, '0);
    compute_filled();

    // random phases with one quiet stretch
    for (phase = 0; requests_sent < 480 || phase < 12; phase++) begin
      idle_pct = (phase >= 6 && phase < 10) ? 0 : 11;
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CfgBasisIdx, 64'($urandom_range(0, 3)));
        write_reg(CfgCoreIdx, pick_value());
      end
      burst = $urandom_range(4, 24);
      for (int k = 0; k < burst; k++) begin
        pick = $urandom_range(0, 19);
        f = 3'($urandom_range(0, 4));
        if (pick < 16)
          send_request(f, 6'($urandom_range(0, cur_pairs - 1)),
                       6'($urandom_range(0, cur_pairs - 1)), pick_value());
        else if (pick < 18)
          send_request(f, 6'($urandom), 6'($urandom), pick_value());
        else
          send_request(pick[0] ? FnSpare6 : FnSpare7, 6'($urandom), 6'($urandom),
                       pick_value());
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
      compute_filled();
    end

    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("Run covered %0d loads and computes (%0d computes, basis sizes 0..3),",
             requests_sent, computes_sent);
    $display("with %0d Fock elements compared.", elements_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ufe_pkg.sv
sv/ufe_mul.sv
sv/ufe_datapath.sv
sv/ufe_ctrl.sv
sv/uhf_fock_and_energy_build.sv
sv/ufe_checker.sv
sim/fock_scoreboard.sv
sim/tb_top.sv
